### sv/binary_bridge_pixel_breaker_core_assert.svh
// Assertion macros used by the checker file of the bridge breaker block.
`ifndef BINARY_BRIDGE_PIXEL_BREAKER_CORE_ASSERT_SVH
`define BINARY_BRIDGE_PIXEL_BREAKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BBPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BBPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bbpb_pkg.sv
// Shared types and constants of the bridge breaker block.
package bbpb_pkg;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int ROW_W        = 12;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic pixel;
        logic cleared;
        logic frame_last;
    } t_result;

endpackage

### sv/binary_bridge_pixel_breaker_core.sv
// Bridge breaker top level: line stores, neighbourhood window and bridge decision.
//
// Usage:
//   Input channel (i_valid / o_stall): one request per raster pixel of the
//   frame, or a drain request (i_drain high) that carries no pixel and pushes
//   out the next pending result. Output channel (o_valid / i_stall): one
//   filtered pixel with its cleared flag and a frame_last marker.
//   Throughput is one request per clock while o_stall stays low. A pixel
//   request causes the result for the pixel image_width+1 places earlier in
//   the stream; that result is registered in the output register, or in the
//   skid stage while the receiver stalls. The two line stores are read at the
//   next read pointer, so their registered data is ready when the request lands.
//   Drain requests flush the tail of a frame, one pending result each.
//   Configuration writes restart the frame and discard what is pending.
//   Reset restores width and height to 1024, empties the pipeline and clears
//   the window; the line stores need no clearing pass.
//   When the receiver stalls, one more result fits in the skid stage; after
//   that o_stall rises until the receiver takes the waiting result.
module binary_bridge_pixel_breaker_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_pixel_in,
    input  logic                             i_drain,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_pixel_out,
    output logic                             o_cleared,
    output logic                             o_frame_last,
    input  logic                             i_cfg_we,
    input  logic [bbpb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bbpb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int RING  = MAX_WIDTH + 2;
    localparam int PW    = $clog2(RING);
    localparam int WU_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WU_W > bbpb_pkg::WIDTH_REG_W) ? WU_W : bbpb_pkg::WIDTH_REG_W;
    localparam int CNT_W = $clog2(MAX_WIDTH + 3);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int HW    = bbpb_pkg::HEIGHT_REG_W;
    localparam int RW    = bbpb_pkg::ROW_W;

    // Ring pointer helpers: advance by one, and step back by a row width.
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(RING - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_back(input logic [PW-1:0] p,
                                               input logic [WU_W-1:0] w);
        logic [PW:0] s;
        s = {1'b0, p} + (PW+1)'(RING) - (PW+1)'(w);
        if (s >= (PW+1)'(RING)) begin
            s = s - (PW+1)'(RING);
        end
        ptr_back = s[PW-1:0];
    endfunction

    // Configuration and control state
    logic [bbpb_pkg::WIDTH_REG_W-1:0]  r_image_width,  n_image_width;
    logic [bbpb_pkg::HEIGHT_REG_W-1:0] r_image_height, n_image_height;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CNT_W-1:0] r_pending, n_pending;
    logic [COL_W-1:0] r_col, n_col;
    logic [RW-1:0]    r_row, n_row;

    // Window: last three originals written, last result, upper-left result
    logic r_l0, r_l1, r_l2, n_l0, n_l1, n_l2;
    logic r_left, r_ul, n_left, n_ul;

    logic [CMP_W-1:0] width_ext;
    logic [WU_W-1:0]  w_used;
    logic [HW-1:0]    h_used;

    logic in_fire, pix_fire, drn_fire, emit, cfg_hit;
    logic [CNT_W-1:0] pend_e;
    logic [CNT_W-1:0] dk_full;
    logic [1:0]       dk;
    logic             g0;
    logic [2:0]       nv;

    logic orig_c, orig_r, proc_up, proc_ur;
    logic center, right, down, down_l, down_r, up, left, up_l, up_r;
    logic [2:0] n4, diag;
    logic hb, vb, db, interior, last_col, last_row, clr, res;

    logic [PW-1:0] orig_rd_a, orig_rd_b, proc_rd_a, proc_rd_b;
    bbpb_pkg::t_result push_data;
    bbpb_pkg::t_result out_data;
    logic              buf_full;

    // Clamp the frame size to the supported range
    assign width_ext = CMP_W'(r_image_width);

    always_comb begin
        if (width_ext == '0) begin
            w_used = WU_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            w_used = WU_W'(MAX_WIDTH);
        end else begin
            w_used = width_ext[WU_W-1:0];
        end
        if (r_image_height == '0) begin
            h_used = HW'(1);
        end else if (r_image_height > HW'(bbpb_pkg::MAX_HEIGHT)) begin
            h_used = HW'(bbpb_pkg::MAX_HEIGHT);
        end else begin
            h_used = r_image_height;
        end
    end

    assign in_fire  = i_valid && !o_stall;
    assign pix_fire = in_fire && !i_drain;
    assign drn_fire = in_fire && i_drain;
    assign cfg_hit  = i_cfg_we && ((i_cfg_index == bbpb_pkg::REG_IMAGE_WIDTH) ||
                                   (i_cfg_index == bbpb_pkg::REG_IMAGE_HEIGHT));

    // Pending count as seen by the emission, including this request's pixel
    assign pend_e = pix_fire ? r_pending + CNT_W'(1) : r_pending;
    assign emit   = (pix_fire && (pend_e == CNT_W'(w_used) + CNT_W'(2))) ||
                    (drn_fire && (r_pending != '0));

    // Distance of the newest pixel beyond the row below's left corner
    assign g0      = pend_e >= CNT_W'(w_used);
    assign dk_full = pend_e - CNT_W'(w_used);
    assign dk      = dk_full[1:0];
    assign nv      = pix_fire ? {r_l1, r_l0, i_pixel_in} : {r_l2, r_l1, r_l0};

    // Row below comes from the newest writes; anything not yet received is background
    always_comb begin
        down_l = 1'b0;
        down   = 1'b0;
        down_r = 1'b0;
        if (g0) begin
            case (dk)
                2'd0: begin
                    down_l = nv[0];
                end
                2'd1: begin
                    down_l = nv[1];
                    down   = nv[0];
                end
                2'd2: begin
                    down_l = nv[2];
                    down   = nv[1];
                    down_r = nv[0];
                end
                default: begin
                    down_l = 1'b0;
                end
            endcase
        end
    end

    assign center = orig_c;
    assign right  = (pend_e > CNT_W'(1)) ? orig_r : 1'b0;
    assign up     = proc_up;
    assign up_r   = proc_ur;
    assign up_l   = r_ul;
    assign left   = r_left;

    // Bridge decision on the in-place neighbourhood
    assign last_col = (WU_W'(r_col) == w_used - WU_W'(1));
    assign last_row = (HW'(r_row) == h_used - HW'(1));
    assign interior = center && (r_row != '0) && !last_row && (r_col != '0) && !last_col;
    assign n4   = 3'(up) + 3'(down) + 3'(left) + 3'(right);
    assign diag = 3'(up_l) + 3'(up_r) + 3'(down_l) + 3'(down_r);
    assign hb   = left && right && !up && !down;
    assign vb   = up && down && !left && !right;
    assign db   = (n4 == 3'd0) && (diag >= 3'd2);
    assign clr  = interior && (n4 <= 3'd2) && (hb || vb || db);
    assign res  = center && !clr;

    // Next state
    always_comb begin
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_pending = r_pending;
        n_col     = r_col;
        n_row     = r_row;
        n_l0      = r_l0;
        n_l1      = r_l1;
        n_l2      = r_l2;
        n_left    = r_left;
        n_ul      = r_ul;

        if (pix_fire) begin
            n_wp = ptr_inc(r_wp);
            n_l0 = i_pixel_in;
            n_l1 = r_l0;
            n_l2 = r_l1;
        end
        if (emit) begin
            n_rp   = ptr_inc(r_rp);
            n_left = res;
            n_ul   = up;
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
        n_pending = r_pending + CNT_W'(pix_fire) - CNT_W'(emit);

        // A register write restarts the frame and drops what is pending
        if (cfg_hit) begin
            unique case (i_cfg_index)
                bbpb_pkg::REG_IMAGE_WIDTH: begin
                    n_image_width = i_cfg_data[bbpb_pkg::WIDTH_REG_W-1:0];
                end
                bbpb_pkg::REG_IMAGE_HEIGHT: begin
                    n_image_height = i_cfg_data[bbpb_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                    n_image_width = r_image_width;
                end
            endcase
            n_pending = '0;
            n_col     = '0;
            n_row     = '0;
            n_rp      = n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bbpb_pkg::WIDTH_REG_W'(bbpb_pkg::WIDTH_RESET);
            r_image_height <= bbpb_pkg::HEIGHT_REG_W'(bbpb_pkg::HEIGHT_RESET);
            r_wp      <= '0;
            r_rp      <= '0;
            r_pending <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_l0      <= 1'b0;
            r_l1      <= 1'b0;
            r_l2      <= 1'b0;
            r_left    <= 1'b0;
            r_ul      <= 1'b0;
        end else begin
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_pending <= n_pending;
            r_col     <= n_col;
            r_row     <= n_row;
            r_l0      <= n_l0;
            r_l1      <= n_l1;
            r_l2      <= n_l2;
            r_left    <= n_left;
            r_ul      <= n_ul;
        end
    end

    // Read every cycle at the next pointer, so the registered data tracks it
    assign orig_rd_a = n_rp;
    assign orig_rd_b = ptr_inc(n_rp);
    assign proc_rd_b = ptr_back(n_rp, w_used);
    assign proc_rd_a = ptr_inc(proc_rd_b);

    // Original pixels: centre and right neighbour
    bbpb_ring_ram #(
        .DEPTH (RING),
        .AW    (PW)
    ) u_orig_ram (
        .i_clk       (i_clk),
        .i_we        (pix_fire),
        .i_wr_addr   (r_wp),
        .i_wr_data   (i_pixel_in),
        .i_rd_addr_a (orig_rd_a),
        .i_rd_addr_b (orig_rd_b),
        .o_rd_data_a (orig_c),
        .o_rd_data_b (orig_r)
    );

    // Filtered pixels: upper-right and up neighbours of the row above
    bbpb_ring_ram #(
        .DEPTH (RING),
        .AW    (PW)
    ) u_proc_ram (
        .i_clk       (i_clk),
        .i_we        (emit),
        .i_wr_addr   (r_rp),
        .i_wr_data   (res),
        .i_rd_addr_a (proc_rd_a),
        .i_rd_addr_b (proc_rd_b),
        .o_rd_data_a (proc_ur),
        .o_rd_data_b (proc_up)
    );

    assign push_data.pixel      = res;
    assign push_data.cleared    = clr;
    assign push_data.frame_last = last_row && last_col;

    bbpb_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (push_data),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_stall (i_stall)
    );

    // Hold off requests only while the skid stage is occupied
    assign o_stall      = buf_full;
    assign o_pixel_out  = out_data.pixel;
    assign o_cleared    = out_data.cleared;
    assign o_frame_last = out_data.frame_last;

endmodule

### sv/bbpb_ring_ram.sv
// Single-bit ring store: one write port, two registered read ports with write forwarding.
module bbpb_ring_ram #(
    parameter int DEPTH = 1026,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic          o_rd_data_a,
    output logic          o_rd_data_b
);

    logic r_mem [DEPTH];
    logic r_rd_a;
    logic r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data reflects a write at the same edge.
    always_ff @(posedge i_clk) begin
        r_rd_a <= (i_we && (i_wr_addr == i_rd_addr_a)) ? i_wr_data : r_mem[i_rd_addr_a];
        r_rd_b <= (i_we && (i_wr_addr == i_rd_addr_b)) ? i_wr_data : r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### sv/bbpb_out_buf.sv
// Result output register with a skid stage behind it.
module bbpb_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bbpb_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    output bbpb_pkg::t_result o_data,
    input  logic              i_stall
);

    logic              r_out_valid;
    logic              r_skid_valid;
    bbpb_pkg::t_result r_out;
    bbpb_pkg::t_result r_skid;
    logic              out_fire;

    assign out_fire = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### sv/bbpb_checker.sv
// Port-level checker for the bridge breaker block, bound to its top level.
`include "binary_bridge_pixel_breaker_core_assert.svh"

module bbpb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_pixel_out,
    input logic o_cleared,
    input logic o_frame_last
);

    // A stalled result holds
    `BBPB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pixel_out) && $stable(o_cleared) && $stable(o_frame_last), "stalled result changed")

    // A cleared pixel always leaves as background
    `BBPB_ASSERT_IMP(a_cleared_bg, i_clk, i_rst_n, o_valid && o_cleared, !o_pixel_out, "cleared pixel left as ink")

    // The last pixel of a frame lies on the border and is never cleared
    `BBPB_ASSERT_IMP(a_last_border, i_clk, i_rst_n, o_valid && o_frame_last, !o_cleared, "frame end pixel cleared")

    // Requests are held off only while a result is waiting
    `BBPB_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, o_valid, "stall without waiting result")

    // A new result appears only after an accepted request
    `BBPB_ASSERT_IMP(a_rise_cause, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && !o_stall), "result without request")

endmodule

bind binary_bridge_pixel_breaker_core bbpb_checker u_bbpb_checker (.*);

### tb/bridge_result_checker.sv
// Checker of the bridge breaker: predicts every filtered pixel and compares it with the output.
module bridge_result_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic                            i_pixel_in,
    input  logic                            i_drain,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic                            o_pixel_out,
    input  logic                            o_cleared,
    input  logic                            o_frame_last,
    input  logic                            i_cfg_we,
    input  logic [bbpb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbpb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_results_owed,
    output int                              o_fault_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = MAX_WIDTH + 2;

    logic [bbpb_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [bbpb_pkg::HEIGHT_REG_W-1:0] height_reg;
    bit                      raw_line [RING];
    bit                      filtered_line [RING];
    int unsigned             head;
    int unsigned             tail;
    int unsigned             backlog;
    int unsigned             frame_pos;
    bbpb_pkg::t_result       filtered_due [$];
    int                      fault_total = 0;
    int                      result_no = 0;

    function automatic int unsigned used_width();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned used_height();
        if (height_reg == '0) return 1;
        if (height_reg > bbpb_pkg::MAX_HEIGHT) return bbpb_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic int unsigned ring_slot(int off);
        return int'((int'(tail) + RING + off) % RING);
    endfunction

    // Original pixel ahead of the output; not yet received reads as background.
    function automatic bit raw_ahead(int off);
        if (off > 0 && off >= int'(backlog)) return 1'b0;
        return raw_line[ring_slot(off)];
    endfunction

    function automatic bit filtered_behind(int off);
        return filtered_line[ring_slot(-off)];
    endfunction

    // Filter the oldest pending pixel and advance the output side.
    function automatic bbpb_pkg::t_result filter_next_pixel();
        int unsigned       w;
        int unsigned       h;
        int unsigned       row;
        int unsigned       col;
        int                sw;
        bit                up;
        bit                left;
        bit                right;
        bit                down;
        int                n4;
        int                diag;
        bbpb_pkg::t_result res;
        w   = used_width();
        h   = used_height();
        row = frame_pos / w;
        col = frame_pos % w;
        sw  = int'(w);
        res.pixel   = raw_line[tail];
        res.cleared = 1'b0;
        if (res.pixel && row != 0 && row + 1 != h && col != 0 && col + 1 != w) begin
            up    = filtered_behind(sw);
            left  = filtered_behind(1);
            right = raw_ahead(1);
            down  = raw_ahead(sw);
            n4    = int'(up) + int'(down) + int'(left) + int'(right);
            if (n4 <= 2) begin
                diag = int'(filtered_behind(sw + 1)) + int'(filtered_behind(sw - 1))
                     + int'(raw_ahead(sw - 1)) + int'(raw_ahead(sw + 1));
                if ((left && right && !up && !down) || (up && down && !left && !right)
                        || (n4 == 0 && diag >= 2)) begin
                    res.pixel   = 1'b0;
                    res.cleared = 1'b1;
                end
            end
        end
        filtered_line[tail] = res.pixel;
        res.frame_last = (frame_pos + 1 == w * h);
        frame_pos = (frame_pos + 1 >= w * h) ? 0 : frame_pos + 1;
        tail      = (tail + 1) % RING;
        backlog   = backlog - 1;
        return res;
    endfunction

    task automatic log_fault(string msg);
        fault_total++;
        if (fault_total <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        bbpb_pkg::t_result got;
        bbpb_pkg::t_result want;
        if (!i_rst_n) begin
            width_reg  = bbpb_pkg::WIDTH_REG_W'(bbpb_pkg::WIDTH_RESET);
            height_reg = bbpb_pkg::HEIGHT_REG_W'(bbpb_pkg::HEIGHT_RESET);
            head       = 0;
            tail       = 0;
            backlog    = 0;
            frame_pos  = 0;
            filtered_due.delete();
        end else begin
            // Results leave before new requests enter: an output never stems from
            // a request accepted at the same edge.
            if (o_valid && !i_stall) begin
                got.pixel      = o_pixel_out;
                got.cleared    = o_cleared;
                got.frame_last = o_frame_last;
                if (filtered_due.size() == 0) begin
                    log_fault($sformatf("result %0d arrived with none expected", result_no));
                end else begin
                    want = filtered_due.pop_front();
                    if (got.pixel !== want.pixel)
                        log_fault($sformatf("result %0d pixel_out: expected %0b, got %0b",
                                            result_no, want.pixel, got.pixel));
                    if (got.cleared !== want.cleared)
                        log_fault($sformatf("result %0d cleared: expected %0b, got %0b",
                                            result_no, want.cleared, got.cleared));
                    if (got.frame_last !== want.frame_last)
                        log_fault($sformatf("result %0d frame_last: expected %0b, got %0b",
                                            result_no, want.frame_last, got.frame_last));
                end
                result_no++;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == bbpb_pkg::REG_IMAGE_WIDTH)
                    width_reg = i_cfg_data[bbpb_pkg::WIDTH_REG_W-1:0];
                else if (i_cfg_index == bbpb_pkg::REG_IMAGE_HEIGHT)
                    height_reg = i_cfg_data[bbpb_pkg::HEIGHT_REG_W-1:0];
                // Restart the frame and drop what is pending.
                if (i_cfg_index == bbpb_pkg::REG_IMAGE_WIDTH ||
                        i_cfg_index == bbpb_pkg::REG_IMAGE_HEIGHT) begin
                    backlog   = 0;
                    frame_pos = 0;
                    tail      = head;
                end
            end
            if (i_valid && !o_stall) begin
                if (i_drain) begin
                    if (backlog != 0) filtered_due.push_back(filter_next_pixel());
                end else begin
                    raw_line[head] = i_pixel_in;
                    head    = (head + 1) % RING;
                    backlog = backlog + 1;
                    if (backlog == used_width() + 2) filtered_due.push_back(filter_next_pixel());
                end
            end
        end
        o_results_owed <= filtered_due.size();
        o_fault_count  <= fault_total;
    end

endmodule

### tb/binary_bridge_pixel_breaker_core_test.sv
// Testbench top of the bridge breaker: request stimulus, output back-pressure and verdict.
module binary_bridge_pixel_breaker_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH = 1024;
    // Far above the slowest correct run: about five hundred requests with random
    // sender gaps and receiver stalls, plus the long hold.
    localparam int LIMIT     = 400000;

    typedef enum int {PAT_NOISE, PAT_ROWS, PAT_COLUMNS, PAT_CHECKER} t_pattern;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            i_pixel_in  = 1'b0;
    logic                            i_drain     = 1'b0;
    logic                            i_stall     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [bbpb_pkg::CFG_IDX_W-1:0]  i_cfg_index = bbpb_pkg::REG_IMAGE_WIDTH;
    logic [bbpb_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            o_stall;
    logic                            o_valid;
    logic                            o_pixel_out;
    logic                            o_cleared;
    logic                            o_frame_last;

    int results_owed;
    int fault_count;
    int cycle_count = 0;
    // Bump to ask the receiver for one long hold-off.
    int hold_ticket = 0;
    // High in the last stretch of the run: no idling on either side.
    bit calm        = 1'b0;

    binary_bridge_pixel_breaker_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_in  (i_pixel_in),
        .i_drain     (i_drain),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_cleared   (o_cleared),
        .o_frame_last(o_frame_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bridge_result_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_in    (i_pixel_in),
        .i_drain       (i_drain),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_cleared     (o_cleared),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_results_owed(results_owed),
        .o_fault_count (fault_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: short random stall bursts, and one long hold-off on request so
    // that the skid stage fills and the block has to stall its input.
    initial begin
        int served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != served) begin
                served = hold_ticket;
                i_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one request and hold it until accepted; sometimes idle first.
    task automatic put_request(input bit pix, input bit drn);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= pix;
        i_drain    <= drn;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold off the sender until every expected result is out, then let the
    // read stage settle so a drain that found nothing has finished.
    task automatic wait_quiet();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the width register, then the height register; only call when quiet.
    task automatic set_size(input logic [bbpb_pkg::CFG_DATA_W-1:0] w_data,
                            input logic [bbpb_pkg::CFG_DATA_W-1:0] h_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= bbpb_pkg::REG_IMAGE_WIDTH;
        i_cfg_data  <= w_data;
        @(posedge i_clk);
        i_cfg_index <= bbpb_pkg::REG_IMAGE_HEIGHT;
        i_cfg_data  <= h_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Push out the tail; the pixel bit rides along and must be ignored.
    task automatic flush(input int n);
        repeat (n) put_request(1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic send_frame3(input bit [8:0] rows);
        for (int k = 8; k >= 0; k--) put_request(rows[k], 1'b0);
    endtask

    // Stream n pixels of a w-wide image; thin stripes and the checkerboard
    // are where bridges live, noise flips a tenth of them.
    task automatic run_pixels(input int w, input int n, input t_pattern pat,
                              input int density, input int hold_at);
        int row;
        int col;
        bit pix;
        bit noise;
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) hold_ticket <= hold_ticket + 1;
            // Drain in the middle of a frame now and then.
            if ($urandom_range(0, 49) == 0) put_request(1'($urandom_range(0, 1)), 1'b1);
            row   = k / w;
            col   = k % w;
            noise = ($urandom_range(0, 9) == 0);
            case (pat)
                PAT_NOISE:   pix = ($urandom_range(0, 99) < density);
                PAT_ROWS:    pix = row[0] ^ noise;
                PAT_COLUMNS: pix = col[0] ^ noise;
                default:     pix = ~(row[0] ^ col[0]) ^ noise;
            endcase
            put_request(pix, 1'b0);
        end
    endtask

    initial begin
        int w;
        int h;
        int n;
        int phase_no;
        int random_px;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame with an interior pixel. Lead with a drain that finds
        // nothing pending and carries an ink bit, then a horizontal bridge and
        // an isolated pixel with four diagonal neighbours, back to back.
        set_size(13'd3, 13'd3);
        put_request(1'b1, 1'b1);
        send_frame3(9'b000_111_000);
        send_frame3(9'b101_010_101);
        flush(5);

        // Zero sizes count as one: every pixel is a border pixel and a frame end.
        wait_quiet();
        set_size(13'd0, 13'd0);
        run_pixels(1, 12, PAT_NOISE, 50, -1);
        flush(3);

        // Oversized registers clamp to the widest and tallest frame; drain the
        // head of the first row so the line stores are not filled.
        wait_quiet();
        set_size(13'd2047, 13'd8191);
        run_pixels(MAX_WIDTH, 30, PAT_NOISE, 50, -1);
        flush(32);

        wait_quiet();
        set_size(13'(MAX_WIDTH), 13'(bbpb_pkg::MAX_HEIGHT));
        run_pixels(MAX_WIDTH, 20, PAT_ROWS, 50, -1);
        flush(22);

        // Random small frames, several frames per phase so frame ends recur.
        phase_no  = 0;
        random_px = 0;
        while (random_px < 320 || phase_no < 5) begin
            w = $urandom_range(3, 9);
            h = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 7) : $urandom_range(1, 2);
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, w * h - 1);
            // Lengthen the phase that carries the long receiver hold-off.
            if (phase_no == 1) n += 60;
            // Tallest legal height, reached by size not by pixel count.
            if (phase_no == 4) h = bbpb_pkg::MAX_HEIGHT;
            wait_quiet();
            // Upper data bits above the width field must be dropped.
            set_size((phase_no == 2) ? (13'h1800 | 13'(w)) : 13'(w), 13'(h));
            run_pixels(w, n, t_pattern'($urandom_range(0, 3)), $urandom_range(20, 80),
                       (phase_no == 1) ? n / 2 : -1);
            flush(w + 2);
            random_px += n;
            phase_no++;
            if (random_px >= 240) calm <= 1'b1;
        end

        wait_quiet();
        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/bbpb_pkg.sv
sv/bbpb_ring_ram.sv
sv/bbpb_out_buf.sv
sv/binary_bridge_pixel_breaker_core.sv
sv/bbpb_checker.sv
tb/bridge_result_checker.sv
tb/binary_bridge_pixel_breaker_core_test.sv
